// ===== src/cmhmb_pkg.sv =====
// ============================================================================
// cmhmb_pkg - shared types and constants for the CAN message history buffer
// Field widths, command and outcome codes, controller states and the
// result bundle passed from the controller to the output register.
// ============================================================================
package cmhmb_pkg;

    localparam int ID_W          = 29;
    localparam int LEN_W         = 4;
    localparam int DATA_W        = 64;
    localparam int SLOT_W        = 4;
    localparam int SLOTS_DEFAULT = 16;

    localparam logic CMD_STORE    = 1'b0;
    localparam logic CMD_RETRIEVE = 1'b1;

    typedef enum logic [1:0] {
        OUT_NEW       = 2'd0,
        OUT_MAILBOX   = 2'd1,
        OUT_RETRIEVED = 2'd2,
        OUT_NONE      = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        outcome_t                outcome;
        logic [SLOT_W-1:0]       slot;
        logic [ID_W-1:0]         id;
        logic [LEN_W-1:0]        len;
        logic [DATA_W-1:0]       data;
    } result_t;

endpackage

// ===== src/can_message_history_mailbox_buffer.sv =====
// ============================================================================
// can_message_history_mailbox_buffer - CAN receive buffer, history/mailbox
// Top level: slot RAMs, controller and the result output register.
// ============================================================================
// A store takes a frame (29-bit identifier, length code, eight data bytes).
// In history mode (cfg_mailbox_mode = 0) it goes to the head slot, the head
// wraps, and unread frames are overwritten without notice; a retrieve hands
// back the frame at the tail and advances it, or reports nothing to retrieve
// and resets both pointers when the buffer is empty. In mailbox mode a store
// replaces the lowest valid slot holding the same identifier, else takes the
// head slot; a retrieve in mailbox mode reports nothing. Each transaction
// yields exactly one result. Items are processed one at a time by a
// controller around two single-read-port slot RAMs (identifier, and length
// plus data). A mailbox store first runs a one-slot-per-cycle identifier
// scan through the RAM read port. The result sits in an output register,
// so the next transaction is taken while the previous result waits on
// m_ready. Write cfg_mailbox_mode only while the block is idle; the
// configuration port is always ready.
// ============================================================================
module can_message_history_mailbox_buffer
    import cmhmb_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [ID_W-1:0]   s_frame_id,
    input  logic [LEN_W-1:0]  s_frame_len,
    input  logic [DATA_W-1:0] s_frame_data,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_outcome,
    output logic [SLOT_W-1:0] m_slot,
    output logic [ID_W-1:0]   m_out_id,
    output logic [LEN_W-1:0]  m_out_len,
    output logic [DATA_W-1:0] m_out_data,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_mailbox_mode
);

    logic                    res_valid;
    logic                    res_ready;
    result_t                 res;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;
    logic [ID_W-1:0]         mem_wid;
    logic [LEN_W+DATA_W-1:0] mem_wframe;
    logic [ID_W-1:0]         mem_rid;
    logic [LEN_W+DATA_W-1:0] mem_rframe;

    logic                    m_valid_reg, m_valid_next;
    result_t                 m_res_reg;

    // Always accept configuration writes; the user must issue them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    // Identifier store, scanned during a mailbox search.
    cmhmb_slot_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_id_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wid),
        .raddr (mem_raddr),
        .rdata (mem_rid)
    );

    // Length code and payload store.
    cmhmb_slot_ram #(
        .WIDTH (LEN_W + DATA_W),
        .DEPTH (SLOTS)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wframe),
        .raddr (mem_raddr),
        .rdata (mem_rframe)
    );

    cmhmb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_frame_id       (s_frame_id),
        .s_frame_len      (s_frame_len),
        .s_frame_data     (s_frame_data),
        .cfg_valid        (cfg_valid),
        .cfg_mailbox_mode (cfg_mailbox_mode),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_raddr        (mem_raddr),
        .mem_wid          (mem_wid),
        .mem_wframe       (mem_wframe),
        .mem_rid          (mem_rid),
        .mem_rframe       (mem_rframe)
    );

    // Take a new result when the output register is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until the result transaction completes.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_outcome  = m_res_reg.outcome;
    assign m_slot     = m_res_reg.slot;
    assign m_out_id   = m_res_reg.id;
    assign m_out_len  = m_res_reg.len;
    assign m_out_data = m_res_reg.data;

endmodule

// ===== src/cmhmb_slot_ram.sv =====
// ============================================================================
// cmhmb_slot_ram - slot storage
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ============================================================================
module cmhmb_slot_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cmhmb_ctrl.sv =====
// ============================================================================
// cmhmb_ctrl - buffer controller
// Sequences store, mailbox search and retrieve over the slot RAMs, keeps
// head/tail pointers and per-slot valid bits, and stages one result.
// ============================================================================
module cmhmb_ctrl
    import cmhmb_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // item channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    input  logic [ID_W-1:0]         s_frame_id,
    input  logic [LEN_W-1:0]        s_frame_len,
    input  logic [DATA_W-1:0]       s_frame_data,
    // configuration
    input  logic                    cfg_valid,
    input  logic                    cfg_mailbox_mode,
    // result toward output register
    output logic                    res_valid,
    input  logic                    res_ready,
    output result_t                 res,
    // slot RAMs
    output logic                    mem_we,
    output logic [IDX_W-1:0]        mem_waddr,
    output logic [IDX_W-1:0]        mem_raddr,
    output logic [ID_W-1:0]         mem_wid,
    output logic [LEN_W+DATA_W-1:0] mem_wframe,
    input  logic [ID_W-1:0]         mem_rid,
    input  logic [LEN_W+DATA_W-1:0] mem_rframe
);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(SLOTS - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, i};
        return w[SLOT_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [IDX_W:0]      scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [IDX_W-1:0]    wslot_reg, wslot_next;
    logic                wnew_reg, wnew_next;
    result_t             res_reg, res_next;
    logic                hit;

    assign hit = pend_reg && valid_reg[pidx_reg] && (mem_rid == id_reg);

    always_comb begin
        state_next = state_reg;
        mode_next  = cfg_valid ? cfg_mailbox_mode : mode_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        valid_next = valid_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        wslot_next = wslot_reg;
        wnew_next  = wnew_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = wslot_reg;
        mem_raddr  = tail_reg;
        mem_wid    = id_reg;
        mem_wframe = {len_reg, data_reg};

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    id_next   = s_frame_id;
                    len_next  = s_frame_len;
                    data_next = s_frame_data;
                    res_next  = '{outcome: OUT_NONE, slot: '0, id: '0, len: '0, data: '0};
                    if (s_cmd == CMD_STORE) begin
                        if (mode_reg) begin
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SEARCH;
                        end else begin
                            wslot_next = head_reg;
                            wnew_next  = 1'b1;
                            state_next = ST_WRITE;
                        end
                    end else if (mode_reg) begin
                        state_next = ST_RESULT;
                    end else if (tail_reg == head_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        state_next = ST_RESULT;
                    end else begin
                        // read issued at tail this cycle
                        res_next.slot = slot_of(tail_reg);
                        tail_next     = next_idx(tail_reg);
                        state_next    = ST_READ;
                    end
                end
            end

            ST_SEARCH: begin
                mem_raddr = scan_reg[IDX_W-1:0];
                if (hit) begin
                    wslot_next = pidx_reg;
                    wnew_next  = 1'b0;
                    state_next = ST_WRITE;
                end else if (scan_reg == (IDX_W+1)'(SLOTS)) begin
                    wslot_next = head_reg;
                    wnew_next  = 1'b1;
                    state_next = ST_WRITE;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_WRITE: begin
                mem_we                = 1'b1;
                valid_next[wslot_reg] = 1'b1;
                res_next.outcome      = wnew_reg ? OUT_NEW : OUT_MAILBOX;
                res_next.slot         = slot_of(wslot_reg);
                if (wnew_reg) begin
                    head_next = next_idx(head_reg);
                end
                state_next = ST_RESULT;
            end

            ST_READ: begin
                res_next.outcome = OUT_RETRIEVED;
                res_next.id      = mem_rid;
                res_next.len     = mem_rframe[LEN_W+DATA_W-1:DATA_W];
                res_next.data    = mem_rframe[DATA_W-1:0];
                state_next       = ST_RESULT;
            end

            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            valid_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        len_reg   <= len_next;
        data_reg  <= data_next;
        pidx_reg  <= pidx_next;
        wslot_reg <= wslot_next;
        wnew_reg  <= wnew_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("controller stayed idle after accepting a transaction");

    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (scan_reg <= (IDX_W+1)'(SLOTS)))
        else $error("mailbox scan ran past the last slot");

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |=> valid_reg[$past(wslot_reg)])
        else $error("written slot not marked valid");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.outcome == OUT_NONE) |->
            (res.slot == '0 && res.id == '0 && res.len == '0 && res.data == '0))
        else $error("empty retrieve carries nonzero fields");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= IDX_W'(SLOTS - 1)) && (tail_reg <= IDX_W'(SLOTS - 1)))
        else $error("head or tail pointer out of range");

endmodule

// ===== bench/can_message_history_mailbox_buffer_tb.sv =====
// ============================================================================
// can_message_history_mailbox_buffer_tb - self-checking bench for the CAN
// history/mailbox receive buffer
// Drives store and retrieve transactions in both buffer modes. A scoreboard
// keeps its own copy of the slot table and both pointers, and predicts one
// result per accepted transaction. It then compares every returned result
// field by field. Sender bursts, receiver stall patterns and one long
// receiver hold-off shift the traffic against the controller's timing.
// ============================================================================
module can_message_history_mailbox_buffer_tb
    import cmhmb_pkg::*;
();

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [ID_W-1:0]   s_frame_id;
    logic [LEN_W-1:0]  s_frame_len;
    logic [DATA_W-1:0] s_frame_data;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_outcome;
    logic [SLOT_W-1:0] m_slot;
    logic [ID_W-1:0]   m_out_id;
    logic [LEN_W-1:0]  m_out_len;
    logic [DATA_W-1:0] m_out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_mailbox_mode;

    always #5 aclk = ~aclk;

    can_message_history_mailbox_buffer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_frame_id       (s_frame_id),
        .s_frame_len      (s_frame_len),
        .s_frame_data     (s_frame_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_outcome        (m_outcome),
        .m_slot           (m_slot),
        .m_out_id         (m_out_id),
        .m_out_len        (m_out_len),
        .m_out_data       (m_out_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_mailbox_mode (cfg_mailbox_mode)
    );

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the slot table, head/tail pointers and the mode,
    // plus the queue of results still owed by the block.
    // ------------------------------------------------------------------------
    class frame_slot_tracker;
        logic [ID_W-1:0]   held_id   [SLOTS_DEFAULT];
        logic [LEN_W-1:0]  held_len  [SLOTS_DEFAULT];
        logic [DATA_W-1:0] held_data [SLOTS_DEFAULT];
        bit                held_valid[SLOTS_DEFAULT];
        int                head;
        int                tail;
        bit                mailbox_on;
        result_t           pending_results[$];
        int                errors;
        int                n_new, n_match, n_read, n_none;

        function void note_frame(logic cmd, logic [ID_W-1:0] id,
                                 logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
            result_t r;
            int      hit;
            r   = '0;
            hit = -1;
            if (cmd == CMD_STORE) begin
                // mailbox mode: lowest written slot with the same identifier wins
                if (mailbox_on) begin
                    for (int i = 0; i < SLOTS_DEFAULT; i++) begin
                        if (held_valid[i] && held_id[i] == id) begin
                            hit = i;
                            break;
                        end
                    end
                end
                if (hit < 0) begin
                    hit       = head;
                    head      = (head + 1) % SLOTS_DEFAULT;
                    r.outcome = OUT_NEW;
                    n_new++;
                end else begin
                    r.outcome = OUT_MAILBOX;
                    n_match++;
                end
                held_id[hit]    = id;
                held_len[hit]   = len;
                held_data[hit]  = data;
                held_valid[hit] = 1'b1;
                r.slot          = SLOT_W'(hit);
            end else if (mailbox_on) begin
                r.outcome = OUT_NONE;
                n_none++;
            end else if (tail == head) begin
                // empty history: both pointers fall back to slot zero
                tail      = 0;
                head      = 0;
                r.outcome = OUT_NONE;
                n_none++;
            end else begin
                r.outcome = OUT_RETRIEVED;
                r.slot    = SLOT_W'(tail);
                r.id      = held_id[tail];
                r.len     = held_len[tail];
                r.data    = held_data[tail];
                tail      = (tail + 1) % SLOTS_DEFAULT;
                n_read++;
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
            $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, seen, want);
            errors++;
        endtask

        task check_result(result_t seen);
            result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, outcome",
                                64'(seen.outcome), 64'(0));
                return;
            end
            want = pending_results.pop_front();
            if (seen.outcome !== want.outcome)
                report_mismatch("outcome", 64'(seen.outcome), 64'(want.outcome));
            if (seen.slot !== want.slot)
                report_mismatch("slot", 64'(seen.slot), 64'(want.slot));
            if (seen.id !== want.id)
                report_mismatch("out_id", 64'(seen.id), 64'(want.id));
            if (seen.len !== want.len)
                report_mismatch("out_len", 64'(seen.len), 64'(want.len));
            if (seen.data !== want.data)
                report_mismatch("out_data", seen.data, want.data);
        endtask
    endclass

    frame_slot_tracker board = new;

    // Stimulus bookkeeping
    int      burst_left;
    int      mode_writes;
    bit      hold_request = 1'b0;
    result_t seen_result;

    // Identifiers reused often so that mailbox matches and duplicate history
    // entries are common; the extremes of the field are in the pool.
    logic [ID_W-1:0] id_pool[6] = '{29'h0000000, 29'h1FFFFFFF, 29'h0ABCDEF,
                                    29'h1555_5555, 29'h0AAA_AAAA, 29'h0000123};

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Note the input
    // first; a result can never belong to a transaction taken at that edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_frame(s_cmd, s_frame_id, s_frame_len, s_frame_data);
            if (m_valid && m_ready) begin
                seen_result.outcome = outcome_t'(m_outcome);
                seen_result.slot    = m_slot;
                seen_result.id      = m_out_id;
                seen_result.len     = m_out_len;
                seen_result.data    = m_out_data;
                board.check_result(seen_result);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: cycle through stall patterns of random length. A hold-off
    // request from the stimulus side parks m_ready low for a long stretch so
    // that the output register and the controller back up into s_ready.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int pattern_sel;
        int pattern_left;
        int hold_left;
        int tick;
        m_ready      = 1'b0;
        pattern_sel  = 0;
        pattern_left = 0;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (pattern_left == 0) begin
                pattern_sel  = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (pattern_sel)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one transaction and hold it until taken. Bursts of random
    // length end in a gap, so valid is only ever lowered and raised on
    // different falling edges.
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic cmd, input logic [ID_W-1:0] id,
                              input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_frame_id   <= id;
        s_frame_len  <= len;
        s_frame_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    // Wait for every owed result, then let the controller settle.
    task automatic drain();
        while (board.pending_results.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // Change the buffer mode with the block idle.
    task automatic write_mode(input logic mode);
        s_valid    <= 1'b0;
        burst_left  = 0;
        drain();
        cfg_valid        <= 1'b1;
        cfg_mailbox_mode <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.mailbox_on = mode;
        mode_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase in a fixed mode. store_pct steers between draining
    // the history (many retrieves, frequent empty reads) and overrunning it.
    task automatic run_random(input logic mode, input int count, input int store_pct,
                              input bit with_holdoff);
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        int                pick;
        write_mode(mode);
        for (int n = 0; n < count; n++) begin
            if (with_holdoff && n == count / 4)
                hold_request = 1'b1;
            cmd  = ($urandom_range(0, 99) < store_pct) ? CMD_STORE : CMD_RETRIEVE;
            pick = $urandom_range(0, 9);
            if (pick < (mode ? 7 : 2))
                id = id_pool[$urandom_range(0, 5)];
            else
                id = ID_W'($urandom);
            len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(9, 15))
                                              : LEN_W'($urandom_range(0, 8));
            case ($urandom_range(0, 7))
                0: data = '0;
                1: data = '1;
                default: data = {$urandom, $urandom};
            endcase
            send_frame(cmd, id, len, data);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_cmd            = CMD_STORE;
        s_frame_id       = '0;
        s_frame_len      = '0;
        s_frame_data     = '0;
        cfg_valid        = 1'b0;
        cfg_mailbox_mode = 1'b0;
        burst_left       = 0;
        mode_writes      = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // History mode: empty read at reset, field extremes, an oversized
        // length code, a duplicate identifier, then read back to empty.
        write_mode(1'b0);
        send_frame(CMD_RETRIEVE, '1, '1, '1);
        send_frame(CMD_STORE, 29'h1FFFFFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(CMD_STORE, 29'h0000000, 4'd0, 64'h0);
        send_frame(CMD_STORE, 29'h0ABCDEF, 4'd15, 64'h0123_4567_89AB_CDEF);
        send_frame(CMD_STORE, 29'h0ABCDEF, 4'd9, 64'hFEDC_BA98_7654_3210);
        repeat (4) send_frame(CMD_RETRIEVE, '0, '0, '0);
        send_frame(CMD_RETRIEVE, '0, '0, '0);

        // Mailbox mode: hit the lowest of two equal identifiers, a new
        // identifier and its overwrite, new-slot stores of both extremes, and a
        // retrieve that must report nothing.
        write_mode(1'b1);
        send_frame(CMD_STORE, 29'h0ABCDEF, 4'd3, 64'h0000_0000_DEAD_BEEF);
        send_frame(CMD_STORE, 29'h1555_5555, 4'd4, 64'h5555_5555_5555_5555);
        send_frame(CMD_STORE, 29'h1555_5555, 4'd5, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame(CMD_STORE, 29'h1FFFFFFF, 4'd1, 64'h0000_0000_0000_00FF);
        send_frame(CMD_RETRIEVE, 29'h1FFFFFFF, 4'd8, '1);
        send_frame(CMD_STORE, 29'h0000000, 4'd2, 64'h8000_0000_0000_0001);

        // Random phases, alternating modes; the receiver hold-off lands in
        // a store-heavy history phase so the buffer also overruns.
        run_random(1'b0, 90, 60, 1'b0);
        run_random(1'b1, 90, 70, 1'b0);
        run_random(1'b0, 90, 30, 1'b0);
        run_random(1'b0, 100, 95, 1'b1);
        run_random(1'b1, 90, 80, 1'b0);
        run_random(1'b0, 90, 50, 1'b0);

        s_valid <= 1'b0;
        drain();

        $display("Run covered %0d new-slot stores, %0d mailbox overwrites, %0d retrieved frames",
                 board.n_new, board.n_match, board.n_read);
        $display("and %0d empty or mailbox-mode retrieves over %0d mode writes",
                 board.n_none, mode_writes);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still pending", board.pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
